FILE: rtl/lctsa_pkg.sv
`timescale 1ns / 1ps

package lctsa_pkg;

	localparam int WINDOW_DEPTH_DEF     = 5;
	localparam int FACTOR_FRAC_BITS_DEF = 8;
	// twice the startup factor of 407.5 counts per gram
	localparam int FALLBACK_X2          = 815;

	localparam int SAMPLE_W  = 24;
	localparam int DELTA_W   = 25;
	localparam int WEIGHT_W  = 32;
	localparam int FACTOR_W  = 31;
	localparam int DIVISOR_W = 33;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TARE   = 2'd1,
		OP_CAL    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		DIV_SAMPLE = 2'd0,
		DIV_CAL    = 2'd1,
		DIV_MEAN   = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     set_pending;
		logic     tare;
		logic     prep;
		logic     div_start;
		div_sel_t div_sel;
		logic     sat;
		logic     push;
		logic     mean;
		logic     cal;
		logic     out_load;
	} lctsa_cmd_t;

	typedef struct packed {
		op_t  op;
		logic tare_pending;
		logic known_zero;
		logic div_done;
		logic out_free;
	} lctsa_status_t;

endpackage

FILE: rtl/load_cell_tare_scale_average.sv
`timescale 1ns / 1ps
// From input transaction to result: a tare request or unused code goes straight from dispatch
// to the output, a tare capture passes the tare state, calibrate runs one divide and sample
// runs two (scale, then window mean). One item is in flight at a time.
// Rate is set by the shared serial divider: one quotient bit per cycle; a stalled output also holds it.
// Reset (arst_n low, asynchronous) clears offset, window and mean, arms tare and
// loads 407.5 counts per gram; the window memory itself is not cleared.

module load_cell_tare_scale_average import lctsa_pkg::*; #(
	parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
	parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [FACTOR_W-1:0] cfg_wr_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [47:0]         s_axis_tdata,  // raw_sample[23:0], known_weight[47:24]
	input  logic [1:0]          s_axis_tuser,  // operation[1:0]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [63:0]         m_axis_tdata,  // weight_grams[31:0], raw_delta[56:32], zeros
	output logic [0:0]          m_axis_tuser   // tare_done[0]
);

	lctsa_cmd_t          cmd;
	lctsa_status_t       status;
	logic [WEIGHT_W-1:0] out_weight;
	logic [DELTA_W-1:0]  out_delta;
	logic                out_tare_done;

	lctsa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	lctsa_datapath #(
		.WINDOW_DEPTH    (WINDOW_DEPTH),
		.FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_op        (op_t'(s_axis_tuser)),
		.in_raw       (s_axis_tdata[SAMPLE_W-1:0]),
		.in_known     (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_weight   (out_weight),
		.out_delta    (out_delta),
		.out_tare_done(out_tare_done)
	);

	assign m_axis_tdata = {{(64-WEIGHT_W-DELTA_W){1'b0}}, out_delta, out_weight};
	assign m_axis_tuser = out_tare_done;

endmodule

FILE: rtl/lctsa_div.sv
`timescale 1ns / 1ps

module lctsa_div #(
	parameter int NUM_W = 35,
	parameter int DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0] trial_c;
	logic [DEN_W:0] diff_c;
	logic           fits_c;

	assign trial_c = {rem_q, quo_q[NUM_W-1]};
	assign diff_c  = trial_c - {1'b0, den_q};
	assign fits_c  = trial_c >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits_c ? diff_c[DEN_W-1:0] : trial_c[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits_c};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

FILE: rtl/lctsa_datapath.sv
`timescale 1ns / 1ps

module lctsa_datapath import lctsa_pkg::*; #(
	parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
	parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [FACTOR_W-1:0]        cfg_wr_data,
	input  op_t                        in_op,
	input  logic signed [SAMPLE_W-1:0] in_raw,
	input  logic signed [SAMPLE_W-1:0] in_known,
	input  lctsa_cmd_t                 cmd,
	output lctsa_status_t              status,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [WEIGHT_W-1:0]        out_weight,
	output logic [DELTA_W-1:0]         out_delta,
	output logic                       out_tare_done
);

	localparam int CNT_W      = $clog2(WINDOW_DEPTH + 1);
	localparam int SLOT_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W      = WEIGHT_W + $clog2(WINDOW_DEPTH);
	localparam int SCALED_W   = SAMPLE_W + FACTOR_FRAC_BITS;
	localparam int DIV_A      = (SCALED_W + 2 > DIVISOR_W) ? SCALED_W + 2 : DIVISOR_W;
	localparam int DIVIDEND_W = (DIV_A > SUM_W) ? DIV_A : SUM_W;
	localparam logic [WEIGHT_W-1:0] FALLBACK =
		WEIGHT_W'((FALLBACK_X2 * (2 ** FACTOR_FRAC_BITS)) / 2);
	localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(WINDOW_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
	localparam logic signed [WEIGHT_W-1:0] INT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic signed [WEIGHT_W-1:0] INT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	// item registers
	op_t                        op_q;
	logic signed [SAMPLE_W-1:0] raw_q;
	logic signed [SAMPLE_W-1:0] known_q;

	// block state
	logic signed [SAMPLE_W-1:0] zero_offset_q;
	logic signed [SAMPLE_W-1:0] last_raw_q;
	logic                       pending_q;
	logic signed [WEIGHT_W-1:0] cpg_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           count_q;
	logic [SLOT_W-1:0]          slot_q;
	logic signed [WEIGHT_W-1:0] mean_q;

	// working registers
	logic [SAMPLE_W-1:0]        delta_mag_q;
	logic                       delta_neg_q;
	logic [WEIGHT_W-1:0]        cpg_mag_q;
	logic                       neg_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic signed [SUM_W-1:0]    base_q;
	logic signed [WEIGHT_W-1:0] rd_q;
	logic signed [WEIGHT_W-1:0] window_mem [WINDOW_DEPTH];

	logic                       out_valid_q;
	logic [WEIGHT_W-1:0]        out_weight_q;
	logic [DELTA_W-1:0]         out_delta_q;
	logic                       out_tare_done_q;

	logic signed [SAMPLE_W-1:0] src_c;
	logic signed [DELTA_W-1:0]  delta_c;
	logic [DELTA_W-1:0]         delta_abs_c;
	logic [WEIGHT_W-1:0]        cpg_abs_c;
	logic [SAMPLE_W-1:0]        known_mag_c;
	logic [SUM_W-1:0]           sum_mag_c;
	logic [SCALED_W-1:0]        scaled_c;
	logic [DIVIDEND_W-1:0]      dividend_c;
	logic [DIVISOR_W-1:0]       divisor_c;
	logic                       sign_c;
	logic                       div_done;
	logic [DIVIDEND_W-1:0]      div_q;
	logic [WEIGHT_W-1:0]        q_lo_c;
	logic                       pos_ovf_c;
	logic                       neg_ovf_c;
	logic signed [WEIGHT_W-1:0] sat_c;
	logic signed [WEIGHT_W-1:0] mean_c;
	logic                       q_nonzero_c;
	logic                       full_c;
	logic signed [SUM_W-1:0]    evict_c;
	logic signed [DELTA_W-1:0]  cur_delta_c;

	assign src_c       = (op_q == OP_CAL) ? last_raw_q : raw_q;
	assign delta_c     = DELTA_W'(src_c) - DELTA_W'(zero_offset_q);
	assign delta_abs_c = delta_c[DELTA_W-1] ? -delta_c : delta_c;
	assign cpg_abs_c   = cpg_q[WEIGHT_W-1] ? -cpg_q : cpg_q;
	assign known_mag_c = known_q[SAMPLE_W-1] ? -known_q : known_q;
	assign sum_mag_c   = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign scaled_c    = SCALED_W'(delta_mag_q) << FACTOR_FRAC_BITS;

	// sample: round half away via (2n + d) / 2d
	always_comb begin
		unique case (cmd.div_sel)
			DIV_SAMPLE: begin
				dividend_c = (DIVIDEND_W'(scaled_c) << 1) + DIVIDEND_W'(cpg_mag_q);
				divisor_c  = {cpg_mag_q, 1'b0};
				sign_c     = delta_neg_q ^ cpg_q[WEIGHT_W-1];
			end
			DIV_CAL: begin
				dividend_c = DIVIDEND_W'(scaled_c);
				divisor_c  = DIVISOR_W'(known_mag_c);
				sign_c     = delta_neg_q ^ known_q[SAMPLE_W-1];
			end
			DIV_MEAN: begin
				dividend_c = DIVIDEND_W'(sum_mag_c);
				divisor_c  = DIVISOR_W'(count_q);
				sign_c     = sum_q[SUM_W-1];
			end
			default: begin
				dividend_c = '0;
				divisor_c  = '0;
				sign_c     = 1'b0;
			end
		endcase
	end

	lctsa_div #(
		.NUM_W(DIVIDEND_W),
		.DEN_W(DIVISOR_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend_c),
		.divisor (divisor_c),
		.done    (div_done),
		.quotient(div_q)
	);

	assign q_lo_c      = div_q[WEIGHT_W-1:0];
	assign pos_ovf_c   = |div_q[DIVIDEND_W-1:WEIGHT_W-1];
	assign neg_ovf_c   = (|div_q[DIVIDEND_W-1:WEIGHT_W]) |
		(div_q[WEIGHT_W-1] & (|div_q[WEIGHT_W-2:0]));
	assign sat_c       = neg_q ? (neg_ovf_c ? INT_MIN : -q_lo_c)
		: (pos_ovf_c ? INT_MAX : q_lo_c);
	assign mean_c      = neg_q ? -q_lo_c : q_lo_c;
	assign q_nonzero_c = |div_q;
	assign full_c      = count_q == DEPTH_C;
	assign evict_c     = full_c ? SUM_W'(rd_q) : '0;
	assign cur_delta_c = DELTA_W'(last_raw_q) - DELTA_W'(zero_offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q <= '0;
			last_raw_q    <= '0;
			pending_q     <= 1'b1;
			cpg_q         <= FALLBACK;
			sum_q         <= '0;
			count_q       <= '0;
			slot_q        <= '0;
			mean_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				cpg_q <= (cfg_wr_data == '0) ? FALLBACK : {1'b0, cfg_wr_data};
			end
			if (cmd.set_pending) begin
				pending_q <= 1'b1;
			end
			if (cmd.tare) begin
				zero_offset_q <= raw_q;
				last_raw_q    <= raw_q;
				pending_q     <= 1'b0;
				mean_q        <= '0;
				sum_q         <= '0;
				count_q       <= '0;
				slot_q        <= '0;
			end
			if (cmd.push) begin
				last_raw_q <= raw_q;
				sum_q      <= base_q + SUM_W'(w_q);
				if (!full_c) begin
					count_q <= count_q + 1'b1;
				end
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
			if (cmd.mean) begin
				mean_q <= mean_c;
			end
			if (cmd.cal && q_nonzero_c) begin
				cpg_q   <= sat_c;
				mean_q  <= WEIGHT_W'(known_q);
				sum_q   <= '0;
				count_q <= '0;
				slot_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= in_op;
			raw_q   <= in_raw;
			known_q <= in_known;
		end
		if (cmd.prep) begin
			delta_mag_q <= delta_abs_c[SAMPLE_W-1:0];
			delta_neg_q <= delta_c[DELTA_W-1];
			cpg_mag_q   <= cpg_abs_c;
		end
		if (cmd.div_start) begin
			neg_q <= sign_c;
		end
		if (cmd.sat) begin
			w_q    <= sat_c;
			base_q <= sum_q - evict_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			window_mem[slot_q] <= w_q;
		end
		rd_q <= window_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_weight_q    <= mean_q;
			out_delta_q     <= cur_delta_c;
			out_tare_done_q <= !pending_q;
		end
	end

	assign status.op           = op_q;
	assign status.tare_pending = pending_q;
	assign status.known_zero   = known_q == '0;
	assign status.div_done     = div_done;
	assign status.out_free     = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign out_weight    = out_weight_q;
	assign out_delta     = out_delta_q;
	assign out_tare_done = out_tare_done_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transaction");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("window count past depth");

	a_slot_follows_count: assert property (@(posedge clk) disable iff (!arst_n)
		!full_c |-> (count_q == CNT_W'(slot_q)))
		else $error("write slot out of step with fill count");

endmodule

FILE: rtl/lctsa_ctrl.sv
`timescale 1ns / 1ps

module lctsa_ctrl import lctsa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lctsa_status_t status,
	output lctsa_cmd_t    cmd
);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_DISPATCH = 13'b0000000000010,
		S_TARE     = 13'b0000000000100,
		S_PREP     = 13'b0000000001000,
		S_DSTART   = 13'b0000000010000,
		S_DWAIT    = 13'b0000000100000,
		S_SAT      = 13'b0000001000000,
		S_PUSH     = 13'b0000010000000,
		S_MSTART   = 13'b0000100000000,
		S_MWAIT    = 13'b0001000000000,
		S_MEAN     = 13'b0010000000000,
		S_CAL      = 13'b0100000000000,
		S_OUT      = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_SAMPLE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (status.op)
					OP_SAMPLE: state_d = status.tare_pending ? S_TARE : S_PREP;
					OP_TARE: begin
						cmd.set_pending = 1'b1;
						state_d         = S_OUT;
					end
					OP_CAL:  state_d = status.known_zero ? S_OUT : S_PREP;
					default: state_d = S_OUT;
				endcase
			end
			S_TARE: begin
				cmd.tare = 1'b1;
				state_d  = S_OUT;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = (status.op == OP_CAL) ? DIV_CAL : DIV_SAMPLE;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (status.div_done) begin
					state_d = (status.op == OP_CAL) ? S_CAL : S_SAT;
				end
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_MSTART;
			end
			S_MSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MEAN;
				state_d       = S_MWAIT;
			end
			S_MWAIT: begin
				if (status.div_done) begin
					state_d = S_MEAN;
				end
			end
			S_MEAN: begin
				cmd.mean = 1'b1;
				state_d  = S_OUT;
			end
			S_CAL: begin
				cmd.cal = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = state_q == S_IDLE;

endmodule
